/* hw/rtl/lkhc_pkg.sv */
package lkhc_pkg;

  localparam int CACHE_DEPTH    = 64;
  localparam int KEY_BITS       = 64;
  localparam int IDX_W          = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CNT_W          = $clog2(CACHE_DEPTH + 1);
  localparam int KEY_W          = 64;
  localparam int STAMP_W        = 64;
  localparam int CFG_W          = 7;
  localparam int SLOT_W         = 6;
  localparam int OUTCOME_W      = 3;
  localparam int CACHE_SIZE_RST = 50;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_CUR_HIT   = 3'd0,
    OC_TABLE_HIT = 3'd1,
    OC_FILLED    = 3'd2,
    OC_EVICTED   = 3'd3,
    OC_FLUSHED   = 3'd4
  } outcome_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FLUSH  = 1'b1
  } command_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               have_free;
    logic [IDX_W-1:0]   first_free;
    logic [STAMP_W-1:0] bound;
    logic [IDX_W-1:0]   oldest;
  } tok_t;

  // entry update broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic                set_key;
    logic [KEY_BITS-1:0] key;
    logic [STAMP_W-1:0]  stamp;
  } wr_t;

  // growth limit: register saturated to 1..CACHE_DEPTH
  function automatic logic [CNT_W-1:0] size_limit(input logic [CFG_W-1:0] sz);
    logic [CFG_W+CNT_W-1:0] wide;
    wide = (CFG_W + CNT_W)'(sz);
    if (wide == '0) begin
      return CNT_W'(1);
    end else if (wide > (CFG_W + CNT_W)'(CACHE_DEPTH)) begin
      return CNT_W'(CACHE_DEPTH);
    end else begin
      return CNT_W'(wide);
    end
  endfunction

endpackage

/* hw/rtl/lru_keyed_handle_cache_unit.sv */
// Fully associative key cache with timestamp LRU, built as a row of
// CACHE_DEPTH cells, one entry each. A flush goes from acceptance straight
// to the result state; a lookup first checks the most recently used slot
// and on a hit there goes to the result state too. Any other lookup sends a
// search token through every cell, one cell per cycle, regardless of how
// many slots are in use. One request is worked on at a time; in_stall is
// high from acceptance until the result is handed to the output register,
// which may still hold an untaken result when the next request is accepted.
// No clearing pass is needed after reset.
module lru_keyed_handle_cache_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [lkhc_pkg::KEY_W-1:0]     in_lookup_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lkhc_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [lkhc_pkg::SLOT_W-1:0]    out_slot,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkhc_pkg::CFG_W-1:0]     cfg_cache_size
);
  import lkhc_pkg::*;

  tok_t                   tok [CACHE_DEPTH+1];
  logic [CACHE_DEPTH-1:0] hit_vec;
  wr_t                    wr;
  logic                   flush;
  logic [KEY_BITS-1:0]    key;
  logic [CNT_W-1:0]       used;

  lkhc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_outcome    (out_outcome),
    .out_slot       (out_slot),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cache_size (cfg_cache_size),
    .hit_vec        (hit_vec),
    .tok_return     (tok[CACHE_DEPTH]),
    .tok_launch     (tok[0]),
    .wr             (wr),
    .flush          (flush),
    .key            (key),
    .used           (used)
  );

  for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
    lkhc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .used     (used),
      .key      (key),
      .wr       (wr),
      .flush    (flush),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .match    (hit_vec[g])
    );
  end

endmodule

/* hw/rtl/lkhc_cell.sv */
module lkhc_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lkhc_pkg::IDX_W-1:0]      cell_idx,
  input  logic [lkhc_pkg::CNT_W-1:0]      used,
  input  logic [lkhc_pkg::KEY_BITS-1:0]   key,
  input  lkhc_pkg::wr_t                   wr,
  input  logic                            flush,
  input  lkhc_pkg::tok_t                  tok_in,
  output lkhc_pkg::tok_t                  tok_out,
  output logic                            match
);
  import lkhc_pkg::*;

  logic                valid_r;
  logic [KEY_BITS-1:0] key_r;
  logic [STAMP_W-1:0]  stamp_r;
  tok_t                tok_r;
  tok_t                tok_nxt;
  logic                in_range;
  logic                sel;

  assign match    = valid_r && (key_r == key);
  assign in_range = CNT_W'(cell_idx) < used;
  assign sel      = wr.en && (wr.idx == cell_idx);
  assign tok_out  = tok_r;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.hit && in_range) begin
      if (!valid_r) begin
        if (!tok_in.have_free) begin
          tok_nxt.have_free  = 1'b1;
          tok_nxt.first_free = cell_idx;
        end
      end else if (match) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = cell_idx;
      end else if (stamp_r < tok_in.bound) begin
        tok_nxt.bound  = stamp_r;
        tok_nxt.oldest = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (flush) begin
        valid_r <= 1'b0;
      end else if (sel && wr.set_key) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= wr.stamp;
      if (wr.set_key) begin
        key_r <= wr.key;
      end
    end
  end

endmodule

/* hw/rtl/lkhc_ctrl.sv */
module lkhc_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [lkhc_pkg::KEY_W-1:0]        in_lookup_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lkhc_pkg::OUTCOME_W-1:0]    out_outcome,
  output logic [lkhc_pkg::SLOT_W-1:0]       out_slot,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lkhc_pkg::CFG_W-1:0]        cfg_cache_size,
  input  logic [lkhc_pkg::CACHE_DEPTH-1:0]  hit_vec,
  input  lkhc_pkg::tok_t                    tok_return,
  output lkhc_pkg::tok_t                    tok_launch,
  output lkhc_pkg::wr_t                     wr,
  output logic                              flush,
  output logic [lkhc_pkg::KEY_BITS-1:0]     key,
  output logic [lkhc_pkg::CNT_W-1:0]        used
);
  import lkhc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    size_r;
  logic [CNT_W-1:0]    used_r;
  logic                cur_valid_r;
  logic [IDX_W-1:0]    cur_slot_r;
  logic [STAMP_W-1:0]  clock_r;
  logic [KEY_BITS-1:0] key_r;
  tok_t                tok0_r;
  wr_t                 wr_r;
  logic                flush_r;
  outcome_t            res_oc_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                out_valid_r;
  outcome_t            out_outcome_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic [CNT_W-1:0]    limit;
  logic                grow;
  logic [IDX_W-1:0]    target;
  outcome_t            fill_oc;
  logic                cur_hit;
  logic [STAMP_W-1:0]  clock_inc;

  assign in_stall    = (state_r != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_slot    = out_slot_r;
  assign tok_launch  = tok0_r;
  assign wr          = wr_r;
  assign flush       = flush_r;
  assign key         = key_r;
  assign used        = used_r;

  assign cur_hit   = cur_valid_r && hit_vec[cur_slot_r];
  assign clock_inc = clock_r + STAMP_W'(1);

  always_comb begin
    limit = size_limit(size_r);
    grow  = !tok_return.have_free && (used_r < limit);
    if (tok_return.have_free) begin
      target = tok_return.first_free;
    end else if (grow) begin
      target = IDX_W'(used_r);
    end else begin
      target = tok_return.oldest;
    end
    fill_oc = (tok_return.have_free || grow) ? OC_FILLED : OC_EVICTED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= CFG_W'(CACHE_SIZE_RST);
      used_r      <= '0;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      clock_r     <= '0;
      tok0_r.vld  <= 1'b0;
      wr_r.en     <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tok0_r.vld <= 1'b0;
      wr_r.en    <= 1'b0;
      flush_r    <= 1'b0;
      if (cfg_valid) begin
        size_r <= cfg_cache_size;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            key_r <= KEY_BITS'(in_lookup_key);
            if (in_command == CMD_FLUSH) begin
              flush_r     <= 1'b1;
              cur_valid_r <= 1'b0;
              res_oc_r    <= OC_FLUSHED;
              res_slot_r  <= '0;
              state_r     <= ST_DONE;
            end else begin
              state_r <= ST_CUR;
            end
          end
        end
        ST_CUR: begin
          clock_r <= clock_inc;
          if (cur_hit) begin
            wr_r.en      <= 1'b1;
            wr_r.idx     <= cur_slot_r;
            wr_r.set_key <= 1'b0;
            wr_r.stamp   <= clock_inc;
            res_oc_r     <= OC_CUR_HIT;
            res_slot_r   <= SLOT_W'(cur_slot_r);
            state_r      <= ST_DONE;
          end else begin
            // bound starts at the advanced clock
            tok0_r.vld        <= 1'b1;
            tok0_r.hit        <= 1'b0;
            tok0_r.hit_idx    <= '0;
            tok0_r.have_free  <= 1'b0;
            tok0_r.first_free <= '0;
            tok0_r.bound      <= clock_inc;
            tok0_r.oldest     <= '0;
            cur_valid_r       <= 1'b0;
            state_r           <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (tok_return.vld) begin
            clock_r      <= clock_inc;
            wr_r.en      <= 1'b1;
            wr_r.stamp   <= clock_inc;
            wr_r.key     <= key_r;
            cur_valid_r  <= 1'b1;
            state_r      <= ST_DONE;
            if (tok_return.hit) begin
              wr_r.idx     <= tok_return.hit_idx;
              wr_r.set_key <= 1'b0;
              cur_slot_r   <= tok_return.hit_idx;
              res_oc_r     <= OC_TABLE_HIT;
              res_slot_r   <= SLOT_W'(tok_return.hit_idx);
            end else begin
              wr_r.idx     <= target;
              wr_r.set_key <= 1'b1;
              cur_slot_r   <= target;
              res_oc_r     <= fill_oc;
              res_slot_r   <= SLOT_W'(target);
              if (grow) begin
                used_r <= used_r + CNT_W'(1);
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_outcome_r <= res_oc_r;
            out_slot_r    <= res_slot_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/lkhc_checker.sv */
module lkhc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_command,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lkhc_pkg::OUTCOME_W-1:0] out_outcome,
  input logic [lkhc_pkg::SLOT_W-1:0]    out_slot
);
  import lkhc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_outcome) && $stable(out_slot))
    else $error("result changed while stalled");

  a_outcome_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome <= OC_FLUSHED))
    else $error("outcome code out of range");

  a_flush_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == OC_FLUSHED) |-> (out_slot == '0))
    else $error("flush result with nonzero slot");

  // one request at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous still in flight");

  // a flush goes through the done state straight to the output register
  a_flush_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command && !(out_valid && out_stall) |=> ##1
      (out_valid && out_outcome == OC_FLUSHED))
    else $error("flush result late");

endmodule

bind lru_keyed_handle_cache_unit lkhc_checker u_lkhc_checker (.*);

/* verif/lru_keyed_handle_cache_unit_test.sv */
module lru_keyed_handle_cache_unit_test;
  import lkhc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_REQS = 200;
  localparam int POOL_N     = 128;

  typedef struct {
    logic             command;
    logic [KEY_W-1:0] key;
  } cache_req_t;

  typedef struct {
    outcome_t            outcome;
    logic [SLOT_W-1:0]   slot;
    longint unsigned     issued_at;
  } cache_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_command = 1'b0;
  logic [KEY_W-1:0]     in_lookup_key = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [SLOT_W-1:0]    out_slot;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_cache_size = '0;

  lru_keyed_handle_cache_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_outcome    (out_outcome),
    .out_slot       (out_slot),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cache_size (cfg_cache_size)
  );

  always #1 clk = ~clk;

  // predicted cache contents
  logic                mdl_valid [CACHE_DEPTH];
  logic [KEY_BITS-1:0] mdl_key   [CACHE_DEPTH];
  logic [STAMP_W-1:0]  mdl_stamp [CACHE_DEPTH];
  int unsigned         mdl_used;
  int unsigned         mdl_cur;
  logic                mdl_cur_valid;
  logic [STAMP_W-1:0]  mdl_clock;
  logic [CFG_W-1:0]    mdl_size;

  cache_req_t    pending_reqs[$];
  cache_result_t expected_results[$];
  logic [KEY_W-1:0] key_pool [POOL_N];

  cache_req_t    next_req;
  cache_result_t exp_res;
  int            gap_left = 0;
  int            burst_left = 0;
  int            stall_left = 0;
  logic          stall_now = 1'b0;
  bit            sender_gaps = 1'b1;
  bit            receiver_stalls = 1'b1;
  int            idle_cycles = 0;
  int            fail_count = 0;
  int            reqs_sent = 0;
  int            cfg_writes = 0;
  int            outcome_seen [5];

  function automatic cache_result_t predict_cache_access(logic command, logic [KEY_W-1:0] req_key);
    cache_result_t       res;
    logic [KEY_BITS-1:0] k;
    int unsigned         walk, lim, first_free, oldest;
    bit                  have_free;
    logic [STAMP_W-1:0]  bound;
    k = req_key[KEY_BITS-1:0];
    res.issued_at = $time;
    if (command_t'(command) == CMD_FLUSH) begin
      for (int i = 0; i < CACHE_DEPTH; i++) mdl_valid[i] = 1'b0;
      mdl_cur_valid = 1'b0;
      res.outcome = OC_FLUSHED;
      res.slot = '0;
      return res;
    end
    if (mdl_cur_valid && mdl_valid[mdl_cur] && mdl_key[mdl_cur] == k) begin
      mdl_clock++;
      mdl_stamp[mdl_cur] = mdl_clock;
      res.outcome = OC_CUR_HIT;
      res.slot = SLOT_W'(mdl_cur);
      return res;
    end
    mdl_cur_valid = 1'b0;
    have_free = 1'b0;
    first_free = 0;
    oldest = 0;
    mdl_clock++;
    bound = mdl_clock;
    walk = (mdl_used > CACHE_DEPTH) ? CACHE_DEPTH : mdl_used;
    for (int i = 0; i < walk; i++) begin
      if (!mdl_valid[i]) begin
        if (!have_free) begin
          have_free = 1'b1;
          first_free = i;
        end
      end else begin
        if (mdl_key[i] == k) begin
          mdl_clock++;
          mdl_stamp[i] = mdl_clock;
          mdl_cur = i;
          mdl_cur_valid = 1'b1;
          res.outcome = OC_TABLE_HIT;
          res.slot = SLOT_W'(i);
          return res;
        end
        if (mdl_stamp[i] < bound) begin
          bound = mdl_stamp[i];
          oldest = i;
        end
      end
    end
    // growth limit: zero behaves as one, anything above the depth as the depth
    lim = (mdl_size == 0) ? 1 : (mdl_size > CACHE_DEPTH) ? CACHE_DEPTH : mdl_size;
    if (!have_free && mdl_used < lim) begin
      have_free = 1'b1;
      first_free = mdl_used;
      mdl_used++;
    end
    if (have_free) begin
      mdl_cur = first_free;
      res.outcome = OC_FILLED;
    end else begin
      mdl_cur = oldest;
      res.outcome = OC_EVICTED;
    end
    mdl_clock++;
    mdl_key[mdl_cur] = k;
    mdl_stamp[mdl_cur] = mdl_clock;
    mdl_valid[mdl_cur] = 1'b1;
    mdl_cur_valid = 1'b1;
    res.slot = SLOT_W'(mdl_cur);
    return res;
  endfunction

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_cache_access(in_command, in_lookup_key));
        reqs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_command <= next_req.command;
          in_lookup_key <= next_req.key;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
              gap_left = ($urandom_range(9) < 6) ? $urandom_range(0, 4) : $urandom_range(5, 90);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        // an expectation pushed in this same step cannot belong to this result
        if (expected_results.size() == 0 || expected_results[0].issued_at == $time) begin
          $error("unexpected result: outcome %0d slot %0d", out_outcome, out_slot);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_outcome !== exp_res.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_res.outcome, out_outcome);
            fail_count++;
          end
          if (out_slot !== exp_res.slot) begin
            $error("slot: expected %0d, got %0d", exp_res.slot, out_slot);
            fail_count++;
          end
          outcome_seen[exp_res.outcome]++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!receiver_stalls || $urandom_range(2) != 0) begin
        stall_now = 1'b0;
        stall_left = $urandom_range(1, 40);
      end else begin
        stall_now = 1'b1;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 6);
      end
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("lru_keyed_handle_cache_unit_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input command_t command, input logic [KEY_W-1:0] key);
    cache_req_t r;
    r.command = command;
    r.key = key;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_cache_size(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_cache_size <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_size = value;
    cfg_writes++;
  endtask

  // mostly keys from a pool larger than the limit, so hits, fills and evictions all occur
  task automatic queue_random_phase(input int n_reqs);
    int unsigned      lim, pool_used, r;
    logic [KEY_W-1:0] last_key;
    lim = (mdl_size == 0) ? 1 : (mdl_size > CACHE_DEPTH) ? CACHE_DEPTH : mdl_size;
    pool_used = lim + lim / 2 + 2;
    last_key = key_pool[0];
    @(negedge clk);
    for (int n = 0; n < n_reqs; n++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        push_req(CMD_FLUSH, {$urandom, $urandom});
      end else begin
        if (r < 23) begin
        end else if (r < 28) begin
          last_key = {$urandom, $urandom};
        end else begin
          last_key = key_pool[$urandom_range(pool_used - 1)];
        end
        push_req(CMD_LOOKUP, last_key);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_sizes [9];
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_key[i] = '0;
      mdl_stamp[i] = '0;
    end
    mdl_used = 0;
    mdl_cur = 0;
    mdl_cur_valid = 1'b0;
    mdl_clock = '0;
    mdl_size = CFG_W'(CACHE_SIZE_RST);
    for (int i = 0; i < 5; i++) outcome_seen[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};
    phase_sizes = '{7'd1, 7'd0, 7'd3, 7'd8, 7'd64, 7'd127, 7'd2, 7'd50, 7'd0};
    phase_sizes[8] = CFG_W'($urandom_range(1, 127));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme keys, both hit kinds, flush and reuse of flushed slots
    @(negedge clk);
    push_req(CMD_LOOKUP, '0);
    push_req(CMD_LOOKUP, '0);
    push_req(CMD_LOOKUP, '1);
    push_req(CMD_LOOKUP, '1);
    push_req(CMD_LOOKUP, '0);
    push_req(CMD_LOOKUP, {32{2'b01}});
    push_req(CMD_LOOKUP, {32{2'b10}});
    push_req(CMD_LOOKUP, '1);
    push_req(CMD_FLUSH, {32{2'b10}});
    push_req(CMD_LOOKUP, {32{2'b10}});
    push_req(CMD_LOOKUP, {32{2'b10}});
    push_req(CMD_FLUSH, '1);
    push_req(CMD_FLUSH, '0);
    push_req(CMD_LOOKUP, 64'd1);
    push_req(CMD_LOOKUP, {1'b1, 63'd0});
    push_req(CMD_LOOKUP, '0);
    push_req(CMD_LOOKUP, 64'd1);
    push_req(CMD_LOOKUP, {1'b1, 63'd0});
    push_req(CMD_LOOKUP, '1);
    push_req(CMD_LOOKUP, '1);
    wait_until_idle();

    // first settings shrink the limit below the slots already in use
    for (int p = 0; p < 9; p++) begin
      sender_gaps = (p != 3);
      receiver_stalls = (p != 3);
      write_cache_size(phase_sizes[p]);
      queue_random_phase(PHASE_REQS);
      wait_until_idle();
    end

    repeat (100) @(posedge clk);
    $display("ran %0d requests over %0d cache_size settings", reqs_sent, cfg_writes);
    $display("current hits %0d, table hits %0d, fills %0d, evictions %0d, flushes %0d",
             outcome_seen[OC_CUR_HIT], outcome_seen[OC_TABLE_HIT], outcome_seen[OC_FILLED],
             outcome_seen[OC_EVICTED], outcome_seen[OC_FLUSHED]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("lru_keyed_handle_cache_unit_test OK");
    end else begin
      $display("lru_keyed_handle_cache_unit_test NOT OK");
    end
    $finish;
  end

endmodule
